// ----- rtl/sdbt_pkg.sv -----
// ----------------------------------------------------------------------------
// SD SPI block transfer package
// Phase codes, register indexes and CRC helpers shared by the engine.
// ----------------------------------------------------------------------------
package sdbt_pkg;

    localparam int BLOCK_BYTES   = 512;
    localparam int R1_POLL_LIMIT = 16;
    localparam int SLOT_W        = 10;
    localparam int POLL_W        = 5;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_SLOT  = 2'd2;

    localparam logic [1:0] CFG_HIGH_CAP  = 2'd0;
    localparam logic [1:0] CFG_CAPACITY  = 2'd1;
    localparam logic [1:0] CFG_CMD_TMO   = 2'd2;
    localparam logic [1:0] CFG_WRITE_TMO = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_IO    = 2'd2;
    localparam logic [1:0] ST_CRC   = 2'd3;

    localparam logic [5:0] CMD_READ   = 6'd17;
    localparam logic [5:0] CMD_WRITE  = 6'd24;
    localparam logic [5:0] CMD_STATUS = 6'd13;

    typedef enum logic [17:0] {
        PH_IDLE       = 18'd1 << 0,
        PH_ARMED      = 18'd1 << 1,
        PH_SEL_DUMMY  = 18'd1 << 2,
        PH_READY_WAIT = 18'd1 << 3,
        PH_CMD        = 18'd1 << 4,
        PH_R1         = 18'd1 << 5,
        PH_TOKEN      = 18'd1 << 6,
        PH_RDATA      = 18'd1 << 7,
        PH_RCRC_HI    = 18'd1 << 8,
        PH_RCRC_LO    = 18'd1 << 9,
        PH_W_GAP      = 18'd1 << 10,
        PH_W_TOKEN    = 18'd1 << 11,
        PH_WDATA      = 18'd1 << 12,
        PH_W_CRC_HI   = 18'd1 << 13,
        PH_W_CRC_LO   = 18'd1 << 14,
        PH_W_RESP     = 18'd1 << 15,
        PH_W_BUSY     = 18'd1 << 16,
        PH_STATUS     = 18'd1 << 17
    } t_phase;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] v;
        c = {1'b0, crc};
        v = b;
        for (int k = 0; k < 8; k++) begin
            c = c << 1;
            if (v[7] ^ c[7]) begin
                c = c ^ 8'h09;
            end
            v = v << 1;
        end
        return c[6:0];
    endfunction

    function automatic logic [6:0] frame_crc7(input logic [5:0] idx, input logic [31:0] arg);
        logic [6:0] c;
        c = crc7_byte(7'd0, {2'b01, idx});
        c = crc7_byte(c, arg[31:24]);
        c = crc7_byte(c, arg[23:16]);
        c = crc7_byte(c, arg[15:8]);
        c = crc7_byte(c, arg[7:0]);
        return c;
    endfunction

endpackage

// ----- rtl/sdbt_cmd_frame.sv -----
// ----------------------------------------------------------------------------
// SD SPI command frame
// Registers command index, argument and CRC7; selects frame bytes by slot.
// ----------------------------------------------------------------------------
module sdbt_cmd_frame (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [5:0]  i_index,
    input  logic [31:0] i_argument,
    input  logic [2:0]  i_sel,
    output logic [5:0]  o_index,
    output logic [7:0]  o_byte
);

    logic [5:0]  r_index;
    logic [31:0] r_argument;
    logic [6:0]  r_crc;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_index    <= i_index;
            r_argument <= i_argument;
            r_crc      <= sdbt_pkg::frame_crc7(i_index, i_argument);
        end
    end

    always_comb begin
        unique case (i_sel)
            3'd0:    o_byte = {2'b01, r_index};
            3'd1:    o_byte = r_argument[31:24];
            3'd2:    o_byte = r_argument[23:16];
            3'd3:    o_byte = r_argument[15:8];
            3'd4:    o_byte = r_argument[7:0];
            default: o_byte = {r_crc, 1'b1};
        endcase
    end

    assign o_index = r_index;

endmodule

// ----- rtl/sd_spi_block_transfer_engine_unit.sv -----
// ----------------------------------------------------------------------------
// SD SPI block transfer engine
// Host-side single block read/write sequencer, one SPI byte slot per item.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): mode 0/1 starts a read/write of
// i_block_number, mode 2 is one SPI byte slot carrying the byte received
// in the previous slot and the next write byte. Each accepted transaction
// yields exactly one result transaction on o_valid/i_ready.
// The result is registered at the accepting edge.
// Throughput is one transaction per cycle while results are taken;
// the output register is refilled in the same cycle it is drained, so
// o_ready follows only whether the result register is free or being taken.
// When the receiver stalls, the result holds and input is refused.
// Configuration writes (i_cfg_valid/o_cfg_ready) are always taken and
// must only happen while the engine is idle.
// Reset returns the engine to idle, timeouts at 65535 and 262143 slots,
// capacity zero, byte addressing.
// ----------------------------------------------------------------------------
module sd_spi_block_transfer_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_block_number,
    input  logic [7:0]  i_received_byte,
    input  logic [7:0]  i_write_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_transmit_byte,
    output logic        o_select_low,
    output logic [7:0]  o_read_data,
    output logic        o_read_data_valid,
    output logic        o_write_data_taken,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [32:0] i_cfg_data
);

    logic        r_high_cap;
    logic [32:0] r_capacity;
    logic [23:0] r_cmd_tmo;
    logic [23:0] r_write_tmo;

    sdbt_pkg::t_phase r_phase, n_phase;
    logic [sdbt_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [23:0] r_tmo, n_tmo;
    logic [sdbt_pkg::POLL_W-1:0] r_poll, n_poll;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_rcrc_hi, n_rcrc_hi;
    logic        r_pend, n_pend;

    logic        r_valid;
    logic [7:0]  r_tx, n_tx;
    logic        r_sel, n_sel;
    logic [7:0]  r_rd, n_rd;
    logic        r_rdv, n_rdv;
    logic        r_taken, n_taken;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [1:0]  r_st, n_st;

    logic        accept;
    logic        load;
    logic [5:0]  load_index;
    logic [31:0] load_arg;
    logic [2:0]  frame_sel;
    logic [5:0]  cmd_index;
    logic [7:0]  frame_byte;
    logic [15:0] crc_rx;
    logic [15:0] crc_wd;
    logic [7:0]  rx;

    assign o_ready     = !r_valid || i_ready;
    assign accept      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign rx          = i_received_byte;
    assign crc_rx      = sdbt_pkg::crc16_byte(r_crc, rx);
    assign crc_wd      = sdbt_pkg::crc16_byte(
                             (r_phase == sdbt_pkg::PH_W_TOKEN) ? 16'd0 : r_crc, i_write_data);

    sdbt_cmd_frame u_frame (
        .i_clk      (i_clk),
        .i_load     (load),
        .i_index    (load_index),
        .i_argument (load_arg),
        .i_sel      (frame_sel),
        .o_index    (cmd_index),
        .o_byte     (frame_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_cap  <= 1'b0;
            r_capacity  <= '0;
            r_cmd_tmo   <= 24'd65535;
            r_write_tmo <= 24'd262143;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sdbt_pkg::CFG_HIGH_CAP:  r_high_cap  <= i_cfg_data[0];
                sdbt_pkg::CFG_CAPACITY:  r_capacity  <= i_cfg_data;
                sdbt_pkg::CFG_CMD_TMO:   r_cmd_tmo   <= i_cfg_data[23:0];
                sdbt_pkg::CFG_WRITE_TMO: r_write_tmo <= i_cfg_data[23:0];
            endcase
        end
    end

    always_comb begin
        logic selected;
        logic fin;
        logic [1:0] fin_st;
        n_phase   = r_phase;
        n_slot    = r_slot;
        n_tmo     = r_tmo;
        n_poll    = r_poll;
        n_crc     = r_crc;
        n_rcrc_hi = r_rcrc_hi;
        n_pend    = r_pend;
        n_tx      = 8'hff;
        n_sel     = 1'b0;
        n_rd      = 8'h00;
        n_rdv     = 1'b0;
        n_taken   = 1'b0;
        n_done    = 1'b0;
        n_st      = sdbt_pkg::ST_OK;
        load      = 1'b0;
        load_index = sdbt_pkg::CMD_READ;
        load_arg  = r_high_cap ? i_block_number : {i_block_number[22:0], 9'd0};
        frame_sel = r_slot[2:0];
        fin       = 1'b0;
        fin_st    = sdbt_pkg::ST_OK;
        selected  = (r_phase != sdbt_pkg::PH_IDLE) && (r_phase != sdbt_pkg::PH_ARMED);

        if (i_mode != sdbt_pkg::MODE_SLOT && i_mode[1] == 1'b0
                && r_phase == sdbt_pkg::PH_IDLE) begin
            if ({1'b0, i_block_number} >= r_capacity
                    || (!r_high_cap && i_block_number[31:23] != 9'd0)) begin
                n_done = 1'b1;
                n_st   = sdbt_pkg::ST_RANGE;
            end else begin
                load       = 1'b1;
                load_index = i_mode[0] ? sdbt_pkg::CMD_WRITE : sdbt_pkg::CMD_READ;
                n_phase    = sdbt_pkg::PH_ARMED;
            end
        end else if (i_mode == sdbt_pkg::MODE_SLOT && r_phase != sdbt_pkg::PH_IDLE) begin
            n_sel = 1'b1;
            unique case (r_phase)
                sdbt_pkg::PH_ARMED: n_phase = sdbt_pkg::PH_SEL_DUMMY;
                sdbt_pkg::PH_SEL_DUMMY: begin
                    n_tmo   = 24'd1;
                    n_phase = sdbt_pkg::PH_READY_WAIT;
                end
                sdbt_pkg::PH_READY_WAIT: begin
                    if (rx == 8'hff) begin
                        frame_sel = 3'd0;
                        n_tx      = frame_byte;
                        n_slot    = 10'd1;
                        n_phase   = sdbt_pkg::PH_CMD;
                    end else if (r_tmo >= r_cmd_tmo) begin
                        fin = 1'b1; fin_st = sdbt_pkg::ST_IO;
                    end else begin
                        n_tmo = r_tmo + 24'd1;
                    end
                end
                sdbt_pkg::PH_CMD: begin
                    if (r_slot < 10'd6) begin
                        n_tx   = frame_byte;
                        n_slot = r_slot + 10'd1;
                    end else begin
                        n_poll  = 5'd1;
                        n_phase = sdbt_pkg::PH_R1;
                    end
                end
                sdbt_pkg::PH_R1: begin
                    if (rx[7] && r_poll < 5'(sdbt_pkg::R1_POLL_LIMIT)) begin
                        n_poll = r_poll + 5'd1;
                    end else if (cmd_index == sdbt_pkg::CMD_STATUS) begin
                        if (rx[7]) begin
                            fin = 1'b1; fin_st = sdbt_pkg::ST_IO;
                        end else begin
                            n_pend  = (rx != 8'h00);
                            n_phase = sdbt_pkg::PH_STATUS;
                        end
                    end else if (rx != 8'h00) begin
                        fin = 1'b1; fin_st = sdbt_pkg::ST_IO;
                    end else if (cmd_index == sdbt_pkg::CMD_WRITE) begin
                        n_phase = sdbt_pkg::PH_W_GAP;
                    end else begin
                        n_tmo   = 24'd1;
                        n_phase = sdbt_pkg::PH_TOKEN;
                    end
                end
                sdbt_pkg::PH_TOKEN: begin
                    if (rx == 8'hfe) begin
                        n_slot  = '0;
                        n_crc   = '0;
                        n_phase = sdbt_pkg::PH_RDATA;
                    end else if (r_tmo >= r_cmd_tmo) begin
                        fin = 1'b1; fin_st = sdbt_pkg::ST_IO;
                    end else begin
                        n_tmo = r_tmo + 24'd1;
                    end
                end
                sdbt_pkg::PH_RDATA: begin
                    n_rd   = rx;
                    n_rdv  = 1'b1;
                    n_crc  = crc_rx;
                    n_slot = r_slot + 10'd1;
                    if (r_slot == 10'(sdbt_pkg::BLOCK_BYTES - 1)) begin
                        n_slot  = '0;
                        n_phase = sdbt_pkg::PH_RCRC_HI;
                    end
                end
                sdbt_pkg::PH_RCRC_HI: begin
                    n_rcrc_hi = rx;
                    n_phase   = sdbt_pkg::PH_RCRC_LO;
                end
                sdbt_pkg::PH_RCRC_LO: begin
                    fin    = 1'b1;
                    fin_st = ({r_rcrc_hi, rx} == r_crc) ? sdbt_pkg::ST_OK : sdbt_pkg::ST_CRC;
                end
                sdbt_pkg::PH_W_GAP: begin
                    n_tx    = 8'hfe;
                    n_phase = sdbt_pkg::PH_W_TOKEN;
                end
                sdbt_pkg::PH_W_TOKEN, sdbt_pkg::PH_WDATA: begin
                    n_phase = sdbt_pkg::PH_WDATA;
                    if (r_phase == sdbt_pkg::PH_W_TOKEN
                            || r_slot < 10'(sdbt_pkg::BLOCK_BYTES)) begin
                        n_tx    = i_write_data;
                        n_taken = 1'b1;
                        n_crc   = crc_wd;
                        n_slot  = (r_phase == sdbt_pkg::PH_W_TOKEN) ? 10'd1 : r_slot + 10'd1;
                    end else begin
                        n_tx    = r_crc[15:8];
                        n_phase = sdbt_pkg::PH_W_CRC_HI;
                    end
                end
                sdbt_pkg::PH_W_CRC_HI: begin
                    n_tx    = r_crc[7:0];
                    n_phase = sdbt_pkg::PH_W_CRC_LO;
                end
                sdbt_pkg::PH_W_CRC_LO: n_phase = sdbt_pkg::PH_W_RESP;
                sdbt_pkg::PH_W_RESP: begin
                    if (rx[4:0] == 5'h05) begin
                        n_tmo   = 24'd1;
                        n_phase = sdbt_pkg::PH_W_BUSY;
                    end else begin
                        fin = 1'b1; fin_st = sdbt_pkg::ST_IO;
                    end
                end
                sdbt_pkg::PH_W_BUSY: begin
                    if (rx == 8'hff) begin
                        n_sel      = 1'b0;
                        load       = 1'b1;
                        load_index = sdbt_pkg::CMD_STATUS;
                        load_arg   = '0;
                        n_phase    = sdbt_pkg::PH_ARMED;
                    end else if (r_tmo >= r_write_tmo) begin
                        fin = 1'b1; fin_st = sdbt_pkg::ST_IO;
                    end else begin
                        n_tmo = r_tmo + 24'd1;
                    end
                end
                sdbt_pkg::PH_STATUS: begin
                    fin    = 1'b1;
                    fin_st = (r_pend || rx != 8'h00) ? sdbt_pkg::ST_IO : sdbt_pkg::ST_OK;
                end
                default: begin
                    fin = 1'b1; fin_st = sdbt_pkg::ST_IO;
                end
            endcase
            if (fin) begin
                n_tx    = 8'hff;
                n_sel   = 1'b0;
                n_done  = 1'b1;
                n_st    = fin_st;
                n_phase = sdbt_pkg::PH_IDLE;
            end
        end else begin
            n_sel = selected;
        end
        n_busy = (n_phase != sdbt_pkg::PH_IDLE);
        if (!accept) begin
            load = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= sdbt_pkg::PH_IDLE;
            r_slot    <= '0;
            r_tmo     <= '0;
            r_poll    <= '0;
            r_crc     <= '0;
            r_rcrc_hi <= '0;
            r_pend    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_slot    <= n_slot;
                r_tmo     <= n_tmo;
                r_poll    <= n_poll;
                r_crc     <= n_crc;
                r_rcrc_hi <= n_rcrc_hi;
                r_pend    <= n_pend;
                r_valid   <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx    <= n_tx;
            r_sel   <= n_sel;
            r_rd    <= n_rd;
            r_rdv   <= n_rdv;
            r_taken <= n_taken;
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_st    <= n_st;
        end
    end

    assign o_valid            = r_valid;
    assign o_transmit_byte    = r_tx;
    assign o_select_low       = r_sel;
    assign o_read_data        = r_rd;
    assign o_read_data_valid  = r_rdv;
    assign o_write_data_taken = r_taken;
    assign o_busy_res         = r_busy;
    assign o_done_res         = r_done;
    assign o_status           = r_st;

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register lost its one-hot code");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_done |-> !r_busy && !r_sel)
        else $error("done result still busy or selected");

    a_read_crc_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == sdbt_pkg::PH_RDATA |-> r_slot < 10'(sdbt_pkg::BLOCK_BYTES))
        else $error("read slot counter beyond block");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_valid && !i_ready) && $past(i_rst_n) |-> $stable(r_phase))
        else $error("state advanced while result stalled");

endmodule
